>>> hdl/osc_pkg.sv
// shared constants, types and sine table for the open-loop sine commutation block
package osc_pkg;

  // sine table
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);

  // register map
  localparam int NUM_REGS  = 5;
  localparam int REG_IDX_W = 3;
  localparam int APB_ADDR_W = $clog2(NUM_REGS * 4);

  localparam logic [REG_IDX_W-1:0] REG_SUPPLY = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZERO   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_POLES  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PWM    = 3'd4;

  localparam logic [15:0] SUPPLY_RST = 16'd12600;
  localparam logic [15:0] LIMIT_RST  = 16'd10000;
  localparam logic [15:0] ZERO_RST   = 16'd0;
  localparam logic [6:0]  POLES_RST  = 7'd7;
  localparam logic [15:0] PWM_RST    = 16'd2399;

  // arithmetic constants
  localparam logic [31:0] DT_MAX     = 32'd500000;
  localparam logic [18:0] DT_DEFAULT = 19'd1000;
  localparam logic [17:0] VEL_GAIN   = 18'd174993;
  localparam logic [15:0] DIV3_RECIP = 16'd43691;
  localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

  typedef logic signed [16:0] sine_t;
  typedef sine_t sine_lut_t [SINE_TABLE_DEPTH];

  // sin(2*pi*i/depth) * 2^15, q30 taylor series, rounded
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t   lut;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic        neg;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x   = (64'(i) * Q30_TWO_PI) / SINE_TABLE_DEPTH;
      neg = 1'b0;
      if (x >= Q30_PI) begin
        x   = x - Q30_PI;
        neg = 1'b1;
      end
      if (x > Q30_HALF_PI) begin
        x = Q30_PI - x;
      end
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      s  = (s * 64'd32768 + (64'd1 << 29)) >> 30;
      lut[i] = neg ? -$signed(s[16:0]) : $signed(s[16:0]);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DT,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_ELEC,
    ST_RDSIN,
    ST_RDCOS,
    ST_AB,
    ST_SB,
    ST_PH,
    ST_MUL3,
    ST_DLD,
    ST_DIV,
    ST_DONE
  } osc_state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DT,
    OP_MUL1,
    OP_MUL2,
    OP_ACC,
    OP_ELEC,
    OP_RDSIN,
    OP_RDCOS,
    OP_AB,
    OP_SB,
    OP_PH,
    OP_MUL3,
    OP_DLD,
    OP_DIV,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] phase;
  } osc_cmd_t;

  typedef struct packed {
    logic out_free;
  } osc_stat_t;

endpackage

>>> hdl/osc_if.sv
// stream interfaces for the input and result channels
interface osc_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_us;
  logic signed [23:0] speed_cmd;
  modport source (output valid, now_us, speed_cmd, input ready);
  modport sink (input valid, now_us, speed_cmd, output ready);
endinterface

interface osc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] compare_a;
  logic [15:0] compare_b;
  logic [15:0] compare_c;
  logic [31:0] shaft_position;
  logic [14:0] drive_millivolts;
  modport source (output valid, compare_a, compare_b, compare_c, shaft_position,
                  drive_millivolts, input ready);
  modport sink (input valid, compare_a, compare_b, compare_c, shaft_position,
                drive_millivolts, output ready);
endinterface

>>> hdl/osc_ctrl.sv
// sequencer for the commutation datapath
module osc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  osc_pkg::osc_stat_t stat,
  output osc_pkg::osc_cmd_t  cmd
);
  import osc_pkg::*;

  osc_state_t state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] divcnt_r, divcnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= 2'd0;
      divcnt_r <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      divcnt_r <= divcnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    divcnt_nxt = divcnt_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_DT;
      ST_DT:    state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_ELEC;
      ST_ELEC:  state_nxt = ST_RDSIN;
      ST_RDSIN: state_nxt = ST_RDCOS;
      ST_RDCOS: state_nxt = ST_AB;
      ST_AB:    state_nxt = ST_SB;
      ST_SB: begin
        state_nxt = ST_PH;
        phase_nxt = 2'd0;
      end
      ST_PH:    state_nxt = ST_MUL3;
      ST_MUL3:  state_nxt = ST_DLD;
      ST_DLD: begin
        state_nxt  = ST_DIV;
        divcnt_nxt = 3'd0;
      end
      ST_DIV: begin
        divcnt_nxt = divcnt_r + 3'd1;
        if (divcnt_r == 3'd7) begin
          if (phase_r == 2'd2) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_PH;
            phase_nxt = phase_r + 2'd1;
          end
        end
      end
      ST_DONE:  if (stat.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.phase = phase_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_DT:    cmd.op = OP_DT;
      ST_MUL1:  cmd.op = OP_MUL1;
      ST_MUL2:  cmd.op = OP_MUL2;
      ST_ACC:   cmd.op = OP_ACC;
      ST_ELEC:  cmd.op = OP_ELEC;
      ST_RDSIN: cmd.op = OP_RDSIN;
      ST_RDCOS: cmd.op = OP_RDCOS;
      ST_AB:    cmd.op = OP_AB;
      ST_SB:    cmd.op = OP_SB;
      ST_PH:    cmd.op = OP_PH;
      ST_MUL3:  cmd.op = OP_MUL3;
      ST_DLD:   cmd.op = OP_DLD;
      ST_DIV:   cmd.op = OP_DIV;
      ST_DONE:  if (stat.out_free) cmd.op = OP_OUT;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> hdl/osc_dp.sv
// commutation datapath: registers, angle integrator, sine rom, transforms, divider
module osc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  osc_pkg::osc_cmd_t                 cmd,
  output osc_pkg::osc_stat_t                stat,
  input  logic [31:0]                       now_us,
  input  logic signed [23:0]                speed_cmd,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       compare_a,
  output logic [15:0]                       compare_b,
  output logic [15:0]                       compare_c,
  output logic [31:0]                       shaft_position,
  output logic [14:0]                       drive_millivolts,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [osc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata
);
  import osc_pkg::*;

  // config registers
  logic [15:0] supply_r, limit_r, zero_r, pwm_r;
  logic [6:0]  poles_r;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= SUPPLY_RST;
      limit_r  <= LIMIT_RST;
      zero_r   <= ZERO_RST;
      poles_r  <= POLES_RST;
      pwm_r    <= PWM_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SUPPLY: supply_r <= pwdata[15:0];
        REG_LIMIT:  limit_r  <= pwdata[15:0];
        REG_ZERO:   zero_r   <= pwdata[15:0];
        REG_POLES:  poles_r  <= pwdata[6:0];
        REG_PWM:    pwm_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SUPPLY: prdata = {16'd0, supply_r};
      REG_LIMIT:  prdata = {16'd0, limit_r};
      REG_ZERO:   prdata = {16'd0, zero_r};
      REG_POLES:  prdata = {25'd0, poles_r};
      REG_PWM:    prdata = {16'd0, pwm_r};
      default:    prdata = 32'd0;
    endcase
  end

  // state carried across items
  logic [31:0] acc_r, last_ts_r;

  // per-item working registers
  logic [31:0]        now_r;
  logic signed [23:0] vel_r;
  logic [23:0]        vmag_r;
  logic               vneg_r;
  logic [18:0]        dt_r;
  logic [42:0]        p1_r;
  logic [60:0]        mag_r;
  logic [14:0]        uq_r;
  logic [32:0]        cap_r;
  logic [31:0]        e_r;
  sine_t              rom_r, sn_r;
  logic signed [31:0] alpha_r, beta_r;
  logic signed [49:0] sb_r;
  logic [47:0]        x_r;
  logic [47:0]        hi_r;
  logic [31:0]        lo_r;
  logic [15:0]        rem_r, dvd_r, q_r;
  logic               dzero_r, dsat_r;
  logic [15:0]        comp_r [3];

  // combinational helpers
  logic [31:0]        dt_raw;
  logic [18:0]        dt_sel;
  logic [61:0]        mag_rnd;
  logic [31:0]        step;
  logic [31:0]        uq_prod;
  logic [31:0]        e_cos;
  logic signed [32:0] prod_a, prod_b;
  logic signed [49:0] sb_prod;
  logic signed [49:0] va, sup_s, u0, u1, u2, u_sel;
  logic [47:0]        lim;
  logic [48:0]        a_sum;
  logic [31:0]        a32;
  logic [16:0]        r1, r2, dsr;
  logic               b1, b2;
  logic [15:0]        r1m, r2m, q_nxt, comp_nxt;

  assign dt_raw  = now_r - last_ts_r;
  assign dt_sel  = (dt_raw == 32'd0 || dt_raw > DT_MAX) ? DT_DEFAULT : dt_raw[18:0];
  assign mag_rnd = {1'b0, mag_r} + 62'd32768;
  assign step    = mag_rnd[47:16];
  assign uq_prod = supply_r * DIV3_RECIP;
  assign e_cos   = e_r + QUARTER_TURN;
  assign prod_a  = $signed({1'b0, uq_r}) * sn_r;
  assign prod_b  = $signed({1'b0, uq_r}) * rom_r;
  assign sb_prod = beta_r * SQRT3_Q16;

  // phase voltages in mV/2^32
  assign va    = 50'(alpha_r) <<< 16;
  assign sup_s = $signed({3'b000, supply_r, 31'd0});
  assign u0    = (va <<< 1) + sup_s;
  assign u1    = sb_r - va + sup_s;
  assign u2    = sup_s - va - sb_r;
  assign lim   = {limit_r, 32'd0};

  always_comb begin
    unique case (cmd.phase)
      2'd0:    u_sel = u0;
      2'd1:    u_sel = u1;
      default: u_sel = u2;
    endcase
  end

  assign a_sum = {1'b0, hi_r} + 49'(lo_r[31:16]);
  assign a32   = a_sum[47:16];

  // two restoring division steps per cycle
  assign dsr = {1'b0, supply_r};
  assign r1  = {rem_r, dvd_r[15]};
  assign b1  = r1 >= dsr;
  assign r1m = b1 ? 16'(r1 - dsr) : r1[15:0];
  assign r2  = {r1m, dvd_r[14]};
  assign b2  = r2 >= dsr;
  assign r2m = b2 ? 16'(r2 - dsr) : r2[15:0];
  assign q_nxt = {q_r[13:0], b1, b2};
  assign comp_nxt = dzero_r ? 16'd0 : (dsat_r ? pwm_r : q_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= 32'd0;
      last_ts_r <= 32'd0;
    end else if (cmd.op == OP_ACC) begin
      acc_r     <= vneg_r ? acc_r - step : acc_r + step;
      last_ts_r <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        now_r <= now_us;
        vel_r <= speed_cmd;
      end
      OP_DT: begin
        dt_r   <= dt_sel;
        vneg_r <= vel_r[23];
        vmag_r <= vel_r[23] ? 24'(24'd0 - vel_r) : vel_r;
      end
      OP_MUL1: p1_r  <= vmag_r * dt_r;
      OP_MUL2: mag_r <= p1_r * VEL_GAIN;
      OP_ACC: begin
        uq_r  <= uq_prod[31:17];
        cap_r <= supply_r * ({1'b0, pwm_r} + 17'd1);
      end
      OP_ELEC:  e_r   <= 32'(acc_r * poles_r) + {zero_r, 16'd0};
      OP_RDSIN: rom_r <= SINE_LUT[e_r[31 -: SINE_IDX_W]];
      OP_RDCOS: begin
        sn_r  <= rom_r;
        rom_r <= SINE_LUT[e_cos[31 -: SINE_IDX_W]];
      end
      OP_AB: begin
        alpha_r <= -$signed(prod_a[31:0]);
        beta_r  <= $signed(prod_b[31:0]);
      end
      OP_SB: sb_r <= sb_prod;
      OP_PH: begin
        if (u_sel[49]) begin
          x_r <= 48'd0;
        end else if (u_sel[48:0] > {1'b0, lim}) begin
          x_r <= lim;
        end else begin
          x_r <= u_sel[47:0];
        end
      end
      OP_MUL3: begin
        hi_r <= x_r[47:16] * pwm_r;
        lo_r <= x_r[15:0] * pwm_r;
      end
      OP_DLD: begin
        rem_r   <= a32[31:16];
        dvd_r   <= a32[15:0];
        q_r     <= 16'd0;
        dzero_r <= (supply_r == 16'd0);
        dsat_r  <= ({1'b0, a32} >= cap_r);
      end
      OP_DIV: begin
        rem_r <= r2m;
        dvd_r <= {dvd_r[13:0], 2'b00};
        q_r   <= q_nxt;
        comp_r[cmd.phase] <= comp_nxt;
      end
      default: ;
    endcase
  end

  // result register
  logic        out_valid_r;
  logic [15:0] oa_r, ob_r, oc_r;
  logic [31:0] opos_r;
  logic [14:0] odrv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      oa_r   <= comp_r[0];
      ob_r   <= comp_r[1];
      oc_r   <= comp_r[2];
      opos_r <= acc_r;
      odrv_r <= uq_r;
    end
  end

  assign stat.out_free    = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign compare_a        = oa_r;
  assign compare_b        = ob_r;
  assign compare_c        = oc_r;
  assign shaft_position   = opos_r;
  assign drive_millivolts = odrv_r;

endmodule

>>> hdl/open_loop_sine_commutation_top.sv
// top level of the open-loop sinusoidal commutation block
//
//  channel   direction  transaction contents
//  in_s      in         now_us, speed_cmd
//  out_s     out        compare_a/b/c, shaft_position, drive_millivolts
//  apb       in/out     supply, limit, zero offset, pole pairs, pwm top
//
// from acceptance to a loaded result register, one item runs through
// nine setup steps, then eleven per phase, set by the shared two-bit-per-cycle divider
// the block takes one item at a time; in_s.ready is high only while the sequencer idles
// a finished result waits in the output register, so the next item can be taken meanwhile
// a stalled output holds the sequencer in its last step until the register frees up
// rst_n is synchronous: clears angle, last timestamp, sequencer, out valid; resets config
module open_loop_sine_commutation_top (
  input  logic                           clk,
  input  logic                           rst_n,
  osc_in_if.sink                         in_s,
  osc_out_if.source                      out_s,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [osc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import osc_pkg::*;

  osc_cmd_t  cmd;
  osc_stat_t stat;
  logic      in_ready;

  // apb never waits
  assign pready     = 1'b1;
  assign in_s.ready = in_ready;

  osc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  osc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .now_us           (in_s.now_us),
    .speed_cmd        (in_s.speed_cmd),
    .out_valid        (out_s.valid),
    .out_ready        (out_s.ready),
    .compare_a        (out_s.compare_a),
    .compare_b        (out_s.compare_b),
    .compare_c        (out_s.compare_c),
    .shaft_position   (out_s.shaft_position),
    .drive_millivolts (out_s.drive_millivolts),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata)
  );

endmodule

>>> hdl/osc_chk.sv
// port checker for the commutation top level
module osc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] compare_a,
  input logic [15:0] compare_b,
  input logic [15:0] compare_c,
  input logic [31:0] shaft_position,
  input logic [14:0] drive_millivolts
);

  // result register empties on reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accepting an item");

  // a result never appears the cycle after acceptance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(compare_a) && $stable(compare_b)
      && $stable(compare_c) && $stable(shaft_position) && $stable(drive_millivolts))
    else $error("stalled result changed");

endmodule

bind open_loop_sine_commutation_top osc_chk u_osc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_s.valid),
  .in_ready         (in_s.ready),
  .out_valid        (out_s.valid),
  .out_ready        (out_s.ready),
  .compare_a        (out_s.compare_a),
  .compare_b        (out_s.compare_b),
  .compare_c        (out_s.compare_c),
  .shaft_position   (out_s.shaft_position),
  .drive_millivolts (out_s.drive_millivolts)
);

>>> tb/osc_commutation_checker.sv
// checker that predicts every commutation result and compares it with the block's output
module osc_commutation_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  osc_in_if                              in_m,
  osc_out_if                             out_m,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [osc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import osc_pkg::*;

  typedef struct packed {
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    logic [31:0] shaft_position;
    logic [14:0] drive_millivolts;
  } pwm_frame_t;

  pwm_frame_t  frame_q[$];
  longint      sine_q15[SINE_TABLE_DEPTH];

  logic [15:0] supply_mv;
  logic [15:0] limit_mv;
  logic [15:0] zero_ofs;
  logic [6:0]  poles;
  logic [15:0] pwm_max;
  logic [31:0] rotor_angle;
  logic [31:0] prev_stamp;

  // q30 taylor series sine, scaled to 2^15 and rounded
  function automatic longint sine_sample(longint unsigned idx);
    longint unsigned x, x2, t, s;
    bit neg;
    x = (idx * 64'd6746518852) / SINE_TABLE_DEPTH;
    neg = 0;
    if (x >= 64'd3373259426) begin
      x = x - 64'd3373259426;
      neg = 1;
    end
    if (x > 64'd1686629713) x = 64'd3373259426 - x;
    x2 = (x * x) >> 30;
    t = 64'd1073741824;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 156;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 110;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 72;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    s = (s * 64'd32768 + (64'd1 << 29)) >> 30;
    return neg ? -longint'(s) : longint'(s);
  endfunction

  initial begin
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) sine_q15[i] = sine_sample(i);
  end

  // phase voltage in mv/2^32 to timer compare value
  function automatic logic [15:0] phase_to_compare(longint u);
    longint lim;
    longint unsigned x, hi, lo, a32, c;
    lim = longint'(limit_mv) * 64'sd4294967296;
    if (supply_mv == 0) return 16'd0;
    if (u < 0) u = 0;
    if (u > lim) u = lim;
    x = u;
    hi = (x >> 16) * pwm_max;
    lo = (x & 64'hFFFF) * pwm_max;
    a32 = (hi + (lo >> 16)) >> 16;
    c = a32 / supply_mv;
    if (c > pwm_max) c = pwm_max;
    return c[15:0];
  endfunction

  // advances the shaft angle and forms the three compare values
  function automatic pwm_frame_t commutate(logic [31:0] now, logic [23:0] vel);
    pwm_frame_t     f;
    logic [31:0]    dt, step, elec, elec_q;
    longint unsigned vmag, mag;
    longint         uq, sn, cs, va, sb, sup;
    dt = now - prev_stamp;
    if (dt == 0 || dt > 32'd500000) dt = 32'd1000;
    vmag = vel[23] ? (64'h100_0000 - vel) : vel;
    mag = vmag * dt * 64'd174993;
    step = 32'((mag + 64'd32768) >> 16);
    rotor_angle = vel[23] ? rotor_angle - step : rotor_angle + step;
    elec = rotor_angle * poles + {zero_ofs, 16'h0};
    elec_q = elec + 32'h4000_0000;
    uq = supply_mv / 3;
    sn = sine_q15[elec[31 -: SINE_IDX_W]];
    cs = sine_q15[elec_q[31 -: SINE_IDX_W]];
    va = -uq * sn * 65536;
    sb = uq * cs * 64'sd113512;
    sup = longint'(supply_mv) * 64'sd2147483648;
    f.compare_a        = phase_to_compare(2 * va + sup);
    f.compare_b        = phase_to_compare(sb - va + sup);
    f.compare_c        = phase_to_compare(-va - sb + sup);
    f.shaft_position   = rotor_angle;
    f.drive_millivolts = uq[14:0];
    prev_stamp = now;
    return f;
  endfunction

  always @(posedge clk) begin
    pwm_frame_t got, want;
    if (!rst_n) begin
      supply_mv   = SUPPLY_RST;
      limit_mv    = LIMIT_RST;
      zero_ofs    = ZERO_RST;
      poles       = POLES_RST;
      pwm_max     = PWM_RST;
      rotor_angle = '0;
      prev_stamp  = '0;
      fail_count  = 0;
      frame_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[APB_ADDR_W-1:2])
          REG_SUPPLY: supply_mv = pwdata[15:0];
          REG_LIMIT:  limit_mv  = pwdata[15:0];
          REG_ZERO:   zero_ofs  = pwdata[15:0];
          REG_POLES:  poles     = pwdata[6:0];
          REG_PWM:    pwm_max   = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_m.valid && out_m.ready) begin
        got = '{out_m.compare_a, out_m.compare_b, out_m.compare_c,
                out_m.shaft_position, out_m.drive_millivolts};
        if (frame_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected transaction: got %p", got);
        end else begin
          want = frame_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (in_m.valid && in_m.ready)
        frame_q.push_back(commutate(in_m.now_us, in_m.speed_cmd));
    end
    pending = frame_q.size();
  end

endmodule

>>> tb/tb_open_loop_sine_commutation_top.sv
// stimulus, configuration and verdict for the open-loop sine commutation block
module tb_open_loop_sine_commutation_top;
  timeunit 1ns;
  timeprecision 1ps;
  import osc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic                  clk;
  logic                  rst_n;
  logic                  psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata, prdata;

  int          fail_count, pending;
  int          idle_pct;    // sender idle percentage
  int          stall_pct;   // receiver stall percentage
  int          cycles = 0;
  logic [31:0] stamp;       // running timestamp

  osc_in_if  in_ch();
  osc_out_if out_ch();

  open_loop_sine_commutation_top dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_s(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  osc_commutation_checker chk (
    .clk(clk), .rst_n(rst_n), .in_m(in_ch), .out_m(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // register write: setup cycle then access cycle
  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold off until the block has drained, then let it finish its last step
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // one transaction on the input channel with random idle cycles ahead of it
  task automatic send_step(logic [31:0] now, logic [23:0] vel);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.now_us    <= now;
    in_ch.speed_cmd <= vel;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // random time step and speed, mostly realistic with occasional odd steps
  task automatic send_random();
    int r;
    logic [31:0] dt;
    logic [23:0] vel;
    r = $urandom_range(0, 99);
    if (r < 5) dt = 0;
    else if (r < 10) dt = 32'd499990 + $urandom_range(0, 20);
    else if (r < 15) dt = $urandom;
    else dt = $urandom_range(1, 3000);
    r = $urandom_range(0, 99);
    if (r < 5) vel = 24'h7FFFFF;
    else if (r < 10) vel = 24'h800000;
    else if (r < 45) vel = 24'($urandom);
    else vel = 24'($urandom_range(0, 1200000) - 600000);
    stamp = stamp + dt;
    send_step(stamp, vel);
  endtask

  // configure while idle, then run a batch of random transactions
  task automatic run_phase(logic [15:0] sup, logic [15:0] lim, logic [15:0] zo,
                           logic [6:0] pp, logic [15:0] top, int snd, int rcv, int n);
    drain();
    reg_write(REG_SUPPLY, 32'(sup));
    reg_write(REG_LIMIT, 32'(lim));
    reg_write(REG_ZERO, 32'(zo));
    reg_write(REG_POLES, 32'(pp));
    reg_write(REG_PWM, 32'(top));
    idle_pct  = snd;
    stall_pct = rcv;
    repeat (n) send_random();
  endtask

  initial begin
    idle_pct             = 0;
    stall_pct            = 0;
    stamp                = '0;
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.now_us        <= '0;
    in_ch.speed_cmd     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: speed extremes, zero and long steps, timestamp wrap
    send_step(32'd0, 24'd0);                 // zero time step
    send_step(32'd1000, 24'h7FFFFF);
    send_step(32'd2000, 24'h800000);
    send_step(32'd502000, 24'd25600);        // exactly the longest step
    send_step(32'd1002001, 24'd25600);       // one beyond the longest step
    send_step(32'hFFFF_FFF0, 24'hFFFFFF);    // huge step falls back to default
    send_step(32'h0000_0100, 24'd1);         // timestamp wraps around
    send_step(32'h0000_0100, 24'h000100);
    send_step(32'h0000_0101, 24'h7FFFFF);
    send_step(32'h0007_A221, 24'h800000);
    send_step(32'hAAAA_AAAA, 24'h555555);
    send_step(32'h5555_5555, 24'hAAAAAA);
    for (int i = 0; i < 8; i++) begin
      stamp = 32'h5555_5555 + (i + 1) * 997;
      send_step(stamp, 24'(24'h7FFFFF - i * 24'h111111));
    end

    run_phase(SUPPLY_RST, LIMIT_RST, ZERO_RST, POLES_RST, PWM_RST, 57, 0, 220);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd64, 16'hFFFF, 0, 57, 220);
    run_phase(16'd1, 16'd0, 16'd0, 7'd1, 16'd1, 9, 9, 140);
    // zero supply, zero pole pairs and zero compare range
    run_phase(16'd0, 16'd500, 16'd4000, 7'd0, 16'd0, 0, 0, 100);
    // limit above supply saturates the duty, out-of-range pole pairs
    run_phase(16'd5000, 16'hFFFF, 16'd12345, 7'd127, 16'd1000, 57, 0, 180);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 7'($urandom), 16'($urandom),
              0, 57, 220);
    run_phase(16'd12000, 16'd12000, 16'($urandom), 7'd7, 16'd2399, 9, 9, 230);
    run_phase(16'd24000, 16'd20000, 16'($urandom), 7'($urandom_range(1, 64)), 16'd4799,
              0, 0, 120);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
